FILE: hdl/bounded_ordered_list_unit_defines.svh
// Assertion macros used by the checker of the ordered list unit.
`ifndef BOUNDED_ORDERED_LIST_UNIT_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define BOL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define BOL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bol_pkg.sv
// Types, constants and address helpers of the bounded ordered list unit.
`default_nettype none

package bol_pkg;

    localparam int DEPTH      = 32;
    localparam int AW         = $clog2(DEPTH);
    localparam int CW         = $clog2(DEPTH + 1);
    localparam int VAL_W      = 32;
    localparam int POS_W      = 6;
    localparam int LEN_W      = 6;
    localparam int ACT_W      = 2;
    localparam int CMP_W      = (CW > POS_W) ? CW : POS_W;
    localparam int IN_DATA_W  = ((VAL_W + POS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((VAL_W + LEN_W + 7) / 8) * 8;

    typedef logic [AW-1:0] addr_t;
    typedef logic [CW-1:0] cnt_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_BACK  = 2'd0,
        ACT_PUSH_FRONT = 2'd1,
        ACT_REMOVE     = 2'd2,
        ACT_DUMP       = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SH_RD,
        ST_SH_WR,
        ST_DUMP
    } state_t;

    // Circular add of a logical offset to the head slot
    function automatic addr_t wrap_add(addr_t base, addr_t off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (AW+1)'(DEPTH))
        begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // Circular step back from the head slot
    function automatic addr_t wrap_dec(addr_t a);
        addr_t res;
        if (a == '0)
        begin
            res = AW'(DEPTH - 1);
        end
        else
        begin
            res = a - 1'b1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/bol_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module bol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bounded_ordered_list_unit.sv
// Top level: ordered list of signed values kept as a ring in one RAM.
// Insert at back or front: result registered the next cycle.
// Remove at position p of length n: one RAM read then one write for each of the n-p
// entries moved; removing the last entry or a failed remove moves nothing.
// Dump of n entries: n results from the RAM read port, one per cycle while the output is not stalled.
// Reset (rst_n low, async) empties the list; RAM contents stay undefined.
`default_nettype none

module bounded_ordered_list_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [bol_pkg::IN_DATA_W-1:0]    s_tdata,   // value, position, zero pad
    input  wire logic [bol_pkg::ACT_W-1:0]        s_tuser,   // action
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [bol_pkg::OUT_DATA_W-1:0]   m_tdata,   // element, length, zero pad
    output logic      [0:0]                       m_tuser,   // ok
    output logic                                  m_tlast
);

    import bol_pkg::*;

    state_t            state_reg, state_next;
    addr_t             head_reg, head_next;
    cnt_t              count_reg, count_next;
    addr_t             idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_ok_reg, out_ok_next;
    logic [VAL_W-1:0]  out_elem_reg, out_elem_next;
    logic              out_last_reg, out_last_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;

    logic              ram_we;
    addr_t             ram_waddr;
    logic [VAL_W-1:0]  ram_wdata;
    logic              ram_re;
    addr_t             ram_raddr;
    logic [VAL_W-1:0]  ram_rdata;

    action_t           in_action;
    logic [VAL_W-1:0]  in_value;
    logic [POS_W-1:0]  in_pos;
    logic              in_fire;
    logic              out_free;
    logic              full;
    logic              pos_ok;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  pos_m1;
    logic              dump_last;

    // List storage
    bol_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Unpack input transaction
    assign in_action = action_t'(s_tuser);
    assign in_value  = s_tdata[VAL_W-1:0];
    assign in_pos    = s_tdata[VAL_W+POS_W-1:VAL_W];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_fire  = s_tvalid && s_tready;

    assign full      = (count_reg == CW'(DEPTH));
    assign pos_ext   = CMP_W'(in_pos);
    assign cnt_ext   = CMP_W'(count_reg);
    assign pos_ok    = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign pos_m1    = pos_ext - 1'b1;
    assign dump_last = ((CW'(idx_reg) + 1'b1) == count_reg);

    // Sequence list operations; RAM accesses never overlap on one entry
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_ok_next    = out_ok_reg;
        out_elem_next  = out_elem_reg;
        out_last_next  = out_last_reg;
        out_len_next   = out_len_reg;
        ram_we         = 1'b0;
        ram_waddr      = head_reg;
        ram_wdata      = in_value;
        ram_re         = 1'b0;
        ram_raddr      = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_action)
                        ACT_PUSH_BACK:
                        begin
                            out_valid_next = 1'b1;
                            out_ok_next    = !full;
                            out_elem_next  = '0;
                            out_last_next  = 1'b1;
                            out_len_next   = LEN_W'(count_reg);
                            if (!full)
                            begin
                                ram_we       = 1'b1;
                                ram_waddr    = wrap_add(head_reg, count_reg[AW-1:0]);
                                count_next   = count_reg + 1'b1;
                                out_len_next = LEN_W'(count_reg + 1'b1);
                            end
                        end
                        ACT_PUSH_FRONT:
                        begin
                            out_valid_next = 1'b1;
                            out_ok_next    = !full;
                            out_elem_next  = '0;
                            out_last_next  = 1'b1;
                            out_len_next   = LEN_W'(count_reg);
                            if (!full)
                            begin
                                ram_we       = 1'b1;
                                ram_waddr    = wrap_dec(head_reg);
                                head_next    = wrap_dec(head_reg);
                                count_next   = count_reg + 1'b1;
                                out_len_next = LEN_W'(count_reg + 1'b1);
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (!pos_ok)
                            begin
                                out_valid_next = 1'b1;
                                out_ok_next    = 1'b0;
                                out_elem_next  = '0;
                                out_last_next  = 1'b1;
                                out_len_next   = LEN_W'(count_reg);
                            end
                            else if (pos_ext == cnt_ext)
                            begin
                                // drop the last entry, nothing to move
                                count_next     = count_reg - 1'b1;
                                out_valid_next = 1'b1;
                                out_ok_next    = 1'b1;
                                out_elem_next  = '0;
                                out_last_next  = 1'b1;
                                out_len_next   = LEN_W'(count_reg - 1'b1);
                            end
                            else
                            begin
                                idx_next   = pos_m1[AW-1:0];
                                state_next = ST_SH_RD;
                            end
                        end
                        ACT_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                out_ok_next    = 1'b0;
                                out_elem_next  = '0;
                                out_last_next  = 1'b1;
                                out_len_next   = '0;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = head_reg;
                                idx_next   = '0;
                                state_next = ST_DUMP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SH_RD:
            begin
                // fetch the entry after the gap
                ram_re     = 1'b1;
                ram_raddr  = wrap_add(head_reg, idx_reg + 1'b1);
                state_next = ST_SH_WR;
            end
            ST_SH_WR:
            begin
                // close the gap by one slot
                ram_we    = 1'b1;
                ram_waddr = wrap_add(head_reg, idx_reg);
                ram_wdata = ram_rdata;
                idx_next  = idx_reg + 1'b1;
                if (({1'b0, CW'(idx_reg)} + 2'd2) < {1'b0, count_reg})
                begin
                    state_next = ST_SH_RD;
                end
                else
                begin
                    count_next     = count_reg - 1'b1;
                    out_valid_next = 1'b1;
                    out_ok_next    = 1'b1;
                    out_elem_next  = '0;
                    out_last_next  = 1'b1;
                    out_len_next   = LEN_W'(count_reg - 1'b1);
                    state_next     = ST_IDLE;
                end
            end
            ST_DUMP:
            begin
                // hold read data until the output stage frees up
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = 1'b1;
                    out_elem_next  = ram_rdata;
                    out_last_next  = dump_last;
                    out_len_next   = LEN_W'(count_reg);
                    if (dump_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next  = idx_reg + 1'b1;
                        ram_re    = 1'b1;
                        ram_raddr = wrap_add(head_reg, idx_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_ok_reg   <= out_ok_next;
        out_elem_reg <= out_elem_next;
        out_last_reg <= out_last_next;
        out_len_reg  <= out_len_next;
    end

    // Pack output transaction
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - VAL_W - LEN_W){1'b0}}, out_len_reg, out_elem_reg};
    assign m_tuser  = out_ok_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

FILE: hdl/bol_checker.sv
// Port-level checker for the ordered list unit and its bind.
`default_nettype none

`include "bounded_ordered_list_unit_defines.svh"

module bol_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [bol_pkg::OUT_DATA_W-1:0]   m_tdata,
    input wire logic [0:0]                       m_tuser,
    input wire logic                             m_tlast
);

    import bol_pkg::*;

    // Stalled output holds its payload
    `BOL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser),
        "output changed while stalled")

    // A failed action ends its run at once
    `BOL_ASSERT_IMP(a_fail_last, m_tvalid && !m_tuser[0], m_tlast, "failed result without last")

    // A failed action carries a zero element
    `BOL_ASSERT_IMP(a_fail_zero, m_tvalid && !m_tuser[0],
        m_tdata[VAL_W-1:0] == '0, "failed result with element")

    // Mid-dump results come from a non-empty list
    `BOL_ASSERT_IMP(a_dump_len, m_tvalid && !m_tlast,
        m_tuser[0] && (m_tdata[VAL_W+LEN_W-1:VAL_W] != '0), "dump result with bad length")

    // Accept input only while the output stage is free
    `BOL_ASSERT_IMP(a_in_gate, s_tvalid && s_tready, !m_tvalid || m_tready,
        "input accepted while output stalled")

endmodule

bind bounded_ordered_list_unit bol_checker u_bol_checker (.*);

`default_nettype wire
